// ===== rtl/core/grct_pkg.sv =====
`default_nettype none
package grct_pkg;

    localparam int CELL_W     = 5;
    localparam int LOC_W      = 7;
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;
    localparam int SHIFT_W    = 5;
    localparam int SIDE_W     = 6;
    localparam int NEAR_W     = 32;

    localparam logic signed [LOC_W-1:0] LOC_LO = -7'sd1;
    localparam logic signed [LOC_W-1:0] LOC_HI = 7'sd33;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_SHIFT    = 3'd2;
    localparam logic [2:0] REG_COLUMNS  = 3'd3;
    localparam logic [2:0] REG_ROWS     = 3'd4;

    typedef enum logic [1:0] {
        ST_CELL      = 2'd0,
        ST_ZERO_MOVE = 2'd1,
        ST_OUTSIDE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CALC,
        F_MUL1,
        F_MUL2,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_END,
        B_FLUSH
    } t_back_state;

    typedef struct packed {
        logic [SIDE_W-1:0]  cols;
        logic [SIDE_W-1:0]  rows;
        logic [SHIFT_W-1:0] shift;
    } t_grid;

    typedef struct packed {
        t_status                  status;
        logic                     end_in;
        logic signed [LOC_W-1:0]  x0;
        logic signed [LOC_W-1:0]  y0;
        logic signed [LOC_W-1:0]  ex;
        logic signed [LOC_W-1:0]  ey;
        logic                     x_pos;
        logic                     y_pos;
        logic                     x_still;
        logic                     y_still;
    } t_job_ctl;

    function automatic logic signed [LOC_W-1:0] clamp_loc(input logic signed [63:0] v);
        logic signed [LOC_W-1:0] r;
        if (v < 64'(LOC_LO)) begin
            r = LOC_LO;
        end else if (v > 64'(LOC_HI)) begin
            r = LOC_HI;
        end else begin
            r = v[LOC_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/grct_queue.sv =====
`default_nettype none
module grct_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full job queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty job queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH)) else $error("job queue count overflow");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/grct_front.sv =====
`default_nettype none
module grct_front
    import grct_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_move_x,
    input  wire logic signed [COORD_BITS-1:0] i_move_y,
    input  wire logic signed [COORD_BITS-1:0] i_origin_x,
    input  wire logic signed [COORD_BITS-1:0] i_origin_y,
    input  wire t_grid                        i_grid,
    input  wire logic                         i_full,
    output logic                              o_push,
    output t_job_ctl                          o_ctl,
    output logic signed [COORD_BITS+38:0]     o_d,
    output logic signed [COORD_BITS+38:0]     o_inc_x,
    output logic signed [COORD_BITS+38:0]     o_inc_y
);
    localparam int CB    = COORD_BITS;
    localparam int REL_W = CB + 2;
    localparam int D_W   = CB + 39;
    localparam int P_W   = NEAR_W + CB;

    t_front_state r_state, n_state;

    logic signed [CB-1:0] r_sx, r_sy, r_mx, r_my;
    t_job_ctl             r_ctl;
    logic [NEAR_W-1:0]    r_nx, r_ny;
    logic [CB-1:0]        r_ax, r_ay;
    logic signed [D_W-1:0] r_inc_x, r_inc_y, r_d;
    logic [P_W-1:0]       r_p1;

    logic signed [REL_W-1:0] rsx, rsy, x_full, y_full, ex_full, ey_full, cols_s, rows_s;
    logic [63:0]          relx64, rely64;
    logic [NEAR_W-1:0]    csize, offx, offy;
    logic [CB-1:0]        ax_c, ay_c;
    logic                 mx_pos, my_pos, zero_move, start_in, end_in;
    t_job_ctl             ctl_c;
    logic [NEAR_W-1:0]    mul_a;
    logic [CB-1:0]        mul_b;
    logic [P_W-1:0]       mul_p;

    // classify the ray and find the first boundary distances
    always_comb begin
        rsx     = REL_W'(r_sx) - REL_W'(i_origin_x);
        rsy     = REL_W'(r_sy) - REL_W'(i_origin_y);
        x_full  = rsx >>> i_grid.shift;
        y_full  = rsy >>> i_grid.shift;
        ex_full = (rsx + REL_W'(r_mx)) >>> i_grid.shift;
        ey_full = (rsy + REL_W'(r_my)) >>> i_grid.shift;
        cols_s  = REL_W'($signed({1'b0, i_grid.cols}));
        rows_s  = REL_W'($signed({1'b0, i_grid.rows}));
        zero_move = (r_mx == '0) && (r_my == '0);
        start_in  = (x_full >= 0) && (x_full < cols_s) && (y_full >= 0) && (y_full < rows_s);
        end_in    = (ex_full >= 0) && (ex_full < cols_s) && (ey_full >= 0) && (ey_full < rows_s);
        mx_pos = !r_mx[CB-1] && (r_mx != '0);
        my_pos = !r_my[CB-1] && (r_my != '0);
        ax_c   = r_mx[CB-1] ? CB'(-r_mx) : CB'(r_mx);
        ay_c   = r_my[CB-1] ? CB'(-r_my) : CB'(r_my);
        relx64 = 64'(rsx);
        rely64 = 64'(rsy);
        csize  = NEAR_W'(1) << i_grid.shift;
        offx   = relx64[NEAR_W-1:0] & (csize - 1'b1);
        offy   = rely64[NEAR_W-1:0] & (csize - 1'b1);

        if (zero_move) begin
            ctl_c.status = ST_ZERO_MOVE;
        end else if (!start_in) begin
            ctl_c.status = ST_OUTSIDE;
        end else begin
            ctl_c.status = ST_CELL;
        end
        ctl_c.end_in  = end_in;
        ctl_c.x0      = clamp_loc(64'(x_full));
        ctl_c.y0      = clamp_loc(64'(y_full));
        ctl_c.ex      = clamp_loc(64'(ex_full));
        ctl_c.ey      = clamp_loc(64'(ey_full));
        ctl_c.x_pos   = mx_pos;
        ctl_c.y_pos   = my_pos;
        ctl_c.x_still = (r_mx == '0);
        ctl_c.y_still = (r_my == '0);
    end

    // one shared multiplier for the two cross products
    always_comb begin
        if (r_state == F_MUL1) begin
            mul_a = r_nx;
            mul_b = r_ay;
        end else begin
            mul_a = r_ny;
            mul_b = r_ax;
        end
        mul_p = P_W'(mul_a) * P_W'(mul_b);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_CALC;
            F_CALC:  n_state = F_MUL1;
            F_MUL1:  n_state = F_MUL2;
            F_MUL2:  n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_PUSH) && !i_full;
    end

    assign o_ctl   = r_ctl;
    assign o_d     = r_d;
    assign o_inc_x = r_inc_x;
    assign o_inc_y = r_inc_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    r_sx <= i_start_x;
                    r_sy <= i_start_y;
                    r_mx <= i_move_x;
                    r_my <= i_move_y;
                end
            end
            F_CALC: begin
                r_ctl   <= ctl_c;
                r_nx    <= mx_pos ? csize - offx : offx;
                r_ny    <= my_pos ? csize - offy : offy;
                r_ax    <= ax_c;
                r_ay    <= ay_c;
                r_inc_x <= D_W'(ay_c) << i_grid.shift;
                r_inc_y <= D_W'(ax_c) << i_grid.shift;
            end
            F_MUL1: r_p1 <= mul_p;
            F_MUL2: r_d  <= D_W'(r_p1) - D_W'(mul_p);
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/grct_back.sv =====
`default_nettype none
module grct_back
    import grct_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    input  wire t_job_ctl                     i_ctl,
    input  wire logic signed [COORD_BITS+38:0] i_d,
    input  wire logic signed [COORD_BITS+38:0] i_inc_x,
    input  wire logic signed [COORD_BITS+38:0] i_inc_y,
    input  wire t_grid                        i_grid,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [CELL_W-1:0]                 o_col,
    output logic [CELL_W-1:0]                 o_row,
    output t_status                           o_status,
    output logic                              o_last
);
    localparam int D_W = COORD_BITS + 39;

    t_back_state r_state, n_state;

    t_job_ctl                r_ctl;
    logic signed [LOC_W-1:0] r_x, r_y;
    logic signed [D_W-1:0]   r_d, r_inc_x, r_inc_y;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_seen, r_have;
    logic [CELL_W-1:0]       r_pend_col, r_pend_row;
    t_status                 r_pend_status;
    logic                    r_out_valid, r_out_last;
    logic [CELL_W-1:0]       r_out_col, r_out_row;
    t_status                 r_out_status;

    logic adv, px, py, outside, term, step_x, emit, add_end, push_out;
    logic signed [LOC_W-1:0] cols_s, rows_s;

    always_comb begin
        adv     = !r_out_valid || i_ready;
        cols_s  = $signed({1'b0, i_grid.cols});
        rows_s  = $signed({1'b0, i_grid.rows});
        px      = r_ctl.x_pos ? (r_x >= r_ctl.ex) : (r_x <= r_ctl.ex);
        py      = r_ctl.y_pos ? (r_y >= r_ctl.ey) : (r_y <= r_ctl.ey);
        outside = (r_x < 0) || (r_x >= cols_s) || (r_y < 0) || (r_y >= rows_s);
        term    = (r_ctl.end_in && px && py) || outside;
        // tie goes to y
        if (r_ctl.x_still) begin
            step_x = 1'b0;
        end else if (r_ctl.y_still) begin
            step_x = 1'b1;
        end else begin
            step_x = r_d < 0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) n_state = (i_ctl.status != ST_CELL) ? B_FLUSH : B_WALK;
            end
            B_WALK: begin
                if (adv && (term || r_cnt == CNT_W'(RESULT_CAP - 1))) n_state = B_END;
            end
            B_END:   if (adv) n_state = B_FLUSH;
            B_FLUSH: if (adv) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == B_IDLE) && !i_empty;
        emit     = (r_state == B_WALK) && adv && !term;
        add_end  = (r_state == B_END) && adv && r_ctl.end_in && !r_seen
                   && (r_cnt < CNT_W'(RESULT_CAP));
        push_out = ((emit || add_end) && r_have) || ((r_state == B_FLUSH) && adv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_have      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_have <= (i_ctl.status != ST_CELL);
                r_cnt  <= '0;
            end else if (emit) begin
                r_have <= 1'b1;
                r_cnt  <= r_cnt + 1'b1;
            end else if (add_end) begin
                r_have <= 1'b1;
            end else if ((r_state == B_FLUSH) && adv) begin
                r_have <= 1'b0;
            end
            if (push_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl         <= i_ctl;
            r_x           <= i_ctl.x0;
            r_y           <= i_ctl.y0;
            r_d           <= i_d;
            r_inc_x       <= i_inc_x;
            r_inc_y       <= i_inc_y;
            r_seen        <= 1'b0;
            r_pend_col    <= '0;
            r_pend_row    <= '0;
            r_pend_status <= i_ctl.status;
        end else if (emit) begin
            r_pend_col    <= r_x[CELL_W-1:0];
            r_pend_row    <= r_y[CELL_W-1:0];
            r_pend_status <= ST_CELL;
            if (r_x == r_ctl.ex && r_y == r_ctl.ey) r_seen <= 1'b1;
            if (step_x) begin
                r_d <= r_d + r_inc_x;
                r_x <= r_ctl.x_pos ? r_x + 1'b1 : r_x - 1'b1;
            end else begin
                r_d <= r_d - r_inc_y;
                r_y <= r_ctl.y_pos ? r_y + 1'b1 : r_y - 1'b1;
            end
        end else if (add_end) begin
            r_pend_col    <= r_ctl.ex[CELL_W-1:0];
            r_pend_row    <= r_ctl.ey[CELL_W-1:0];
            r_pend_status <= ST_CELL;
        end
        if (push_out) begin
            r_out_col    <= r_pend_col;
            r_out_row    <= r_pend_row;
            r_out_status <= r_pend_status;
            r_out_last   <= (r_state == B_FLUSH);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_col    = r_out_col;
    assign o_row    = r_out_row;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

`ifndef SYNTHESIS
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RESULT_CAP)) else $error("cell count beyond cap");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_CELL) |-> r_out_last)
        else $error("status result not marked last");
    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FLUSH) |-> r_have) else $error("flush with no pending result");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/grid_ray_cell_traversal_unit.sv =====
`default_nettype none
// Channel   Dir  Beat contents
// s_axis    in   tdata: start_x, start_y, move_x, move_y (COORD_BITS each, low first)
// m_axis    out  tdata: cell_col[4:0], cell_row[9:5], status[11:10]; tlast: last
// apb       in   origin_x @0x00, origin_y @0x04, cell_shift @0x08,
//                grid_columns @0x0C, grid_rows @0x10
//
// The front takes one ray at a time: it classifies it and computes the
// initial crossing difference with one shared multiplier, then queues it.
// The back walks one cell per cycle, unless the output stalls, from an
// incremental difference register; the walk stops at the result cap. It
// then adds the end cell if needed and flushes; a status-only ray only flushes.
// Reset is synchronous and active low; control and APB registers return to defaults.
// Either side stalls on its own; results wait in an output register.
module grid_ray_cell_traversal_unit
    import grct_pkg::*;
#(
    parameter int MAX_SIDE_CELLS = 32,
    parameter int COORD_BITS     = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // start_x, start_y, move_x, move_y from bit 0 up
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // cell_col, cell_row, status from bit 0 up
    output logic [15:0]                  m_axis_tdata,
    output logic                         m_axis_tlast,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [4:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    localparam int CB  = COORD_BITS;
    localparam int D_W = CB + 39;
    localparam int Q_W = $bits(t_job_ctl) + 3 * D_W;

    logic signed [CB-1:0]  r_origin_x, r_origin_y;
    logic [SHIFT_W-1:0]    r_shift;
    logic [SIDE_W-1:0]     r_cols, r_rows;
    logic [2:0]            reg_idx;
    logic                  wr_en;
    t_grid                 grid;

    // front to queue, queue to back
    logic                  f_push, q_full, q_empty, q_pop;
    t_job_ctl              f_ctl, q_ctl;
    logic signed [D_W-1:0] f_d, f_inc_x, f_inc_y, q_d, q_inc_x, q_inc_y;
    logic [Q_W-1:0]        q_in, q_out;

    logic [CELL_W-1:0]     b_col, b_row;
    t_status               b_status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_shift    <= SHIFT_W'(8);
            r_cols     <= SIDE_W'(32);
            r_rows     <= SIDE_W'(32);
        end else if (wr_en) begin
            case (reg_idx)
                REG_ORIGIN_X: r_origin_x <= pwdata[CB-1:0];
                REG_ORIGIN_Y: r_origin_y <= pwdata[CB-1:0];
                REG_SHIFT:    r_shift    <= pwdata[SHIFT_W-1:0];
                REG_COLUMNS:  r_cols     <= pwdata[SIDE_W-1:0];
                REG_ROWS:     r_rows     <= pwdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ORIGIN_X: prdata = 32'(r_origin_x);
            REG_ORIGIN_Y: prdata = 32'(r_origin_y);
            REG_SHIFT:    prdata = 32'(r_shift);
            REG_COLUMNS:  prdata = 32'(r_cols);
            REG_ROWS:     prdata = 32'(r_rows);
            default:      prdata = '0;
        endcase
    end

    // saturate the grid size to what the output indices can hold
    always_comb begin
        grid.cols  = (r_cols > SIDE_W'(MAX_SIDE_CELLS)) ? SIDE_W'(MAX_SIDE_CELLS) : r_cols;
        grid.rows  = (r_rows > SIDE_W'(MAX_SIDE_CELLS)) ? SIDE_W'(MAX_SIDE_CELLS) : r_rows;
        grid.shift = r_shift;
    end

    grct_front #(.COORD_BITS(CB)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_start_x  (s_axis_tdata[CB-1:0]),
        .i_start_y  (s_axis_tdata[2*CB-1:CB]),
        .i_move_x   (s_axis_tdata[3*CB-1:2*CB]),
        .i_move_y   (s_axis_tdata[4*CB-1:3*CB]),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_grid     (grid),
        .i_full     (q_full),
        .o_push     (f_push),
        .o_ctl      (f_ctl),
        .o_d        (f_d),
        .o_inc_x    (f_inc_x),
        .o_inc_y    (f_inc_y)
    );

    assign q_in = {f_ctl, f_d, f_inc_x, f_inc_y};
    assign {q_ctl, q_d, q_inc_x, q_inc_y} = q_out;

    grct_queue #(.WIDTH(Q_W), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    grct_back #(.COORD_BITS(CB)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_ctl    (q_ctl),
        .i_d      (q_d),
        .i_inc_x  (q_inc_x),
        .i_inc_y  (q_inc_y),
        .i_grid   (grid),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_col    (b_col),
        .o_row    (b_row),
        .o_status (b_status),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, b_status, b_row, b_col};
endmodule
`default_nettype wire
